### design/frsm_pkg.sv
// Constants, types and modular add/subtract helpers for the Fibonacci range-sum block.
`default_nettype none

package frsm_pkg;

  localparam int ELEM_W = 30;
  localparam int MUL_W  = 31;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [ELEM_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [MUL_W-1:0]  BARRETT_MU = 31'd1152921496;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_BAR1,
    ST_BAR2,
    ST_FIX,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_AA,
    OP_BB,
    OP_BT
  } mm_op_t;

  function automatic elem_t mod_add(elem_t x, elem_t y);
    logic [ELEM_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[ELEM_W-1:0];
  endfunction

  function automatic elem_t mod_sub(elem_t x, elem_t y);
    logic [ELEM_W:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, PRIME} - {1'b0, y};
    end
    return s[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/fibonacci_range_sum_mod.sv
// The result strobe follows the accepted request after two passes over the exponent bits
// (first index, then last index plus one); each bit is worked on one 31x31 multiplier that
// serves the three products and both Barrett reduction products of each modular multiply.
// No new request is taken while one is in progress; busy stays high until the strobe cycle, in which
// the next request may already be accepted. The receiver cannot stall the result.
// Reset: synchronous, active low; returns to idle and drops busy and the strobe.
`default_nettype none

module fibonacci_range_sum_mod #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [INDEX_BITS-1:0]           in_first_index,
  input  wire logic [INDEX_BITS-1:0]           in_last_index,
  output logic                                 out_valid,
  output logic [frsm_pkg::ELEM_W-1:0]          out_range_sum
);

  localparam int EXP_W = INDEX_BITS + 1;
  localparam int CNT_W = $clog2(INDEX_BITS + 1);

  frsm_pkg::state_t state_r, state_nxt;
  frsm_pkg::mm_op_t op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pass_r, pass_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [EXP_W-1:0] mplus_r, mplus_nxt;
  frsm_pkg::elem_t  a_r, a_nxt;
  frsm_pkg::elem_t  b_r, b_nxt;
  frsm_pkg::elem_t  t_r, t_nxt;
  frsm_pkg::elem_t  sa_r, sa_nxt;
  frsm_pkg::elem_t  sb_r, sb_nxt;
  frsm_pkg::elem_t  sc_r, sc_nxt;
  frsm_pkg::elem_t  lo_r, lo_nxt;
  logic [31:0]      x_r, x_nxt;
  logic [frsm_pkg::PROD_W-1:0] prod_r;
  logic             out_valid_r, out_valid_nxt;
  frsm_pkg::elem_t  out_range_sum_r, out_range_sum_nxt;

  logic [frsm_pkg::MUL_W-1:0]  ma, mb;
  logic [frsm_pkg::PROD_W-1:0] mult;
  logic [31:0]     rem;
  logic [31:0]     p1, p2;
  frsm_pkg::elem_t fix_val;
  frsm_pkg::elem_t dbl;
  frsm_pkg::elem_t a_upd, b_upd;

  assign busy          = (state_r != frsm_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_range_sum_r;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      frsm_pkg::ST_BAR1: begin
        ma = prod_r[59:29];
        mb = frsm_pkg::BARRETT_MU;
      end
      frsm_pkg::ST_BAR2: begin
        ma = prod_r[61:31];
        mb = {1'b0, frsm_pkg::PRIME};
      end
      default: begin
        case (op_r)
          frsm_pkg::OP_BB: begin
            ma = {1'b0, b_r};
            mb = {1'b0, b_r};
          end
          frsm_pkg::OP_BT: begin
            ma = {1'b0, b_r};
            mb = {1'b0, t_r};
          end
          default: begin
            ma = {1'b0, a_r};
            mb = {1'b0, a_r};
          end
        endcase
      end
    endcase
  end

  assign mult = {{frsm_pkg::MUL_W{1'b0}}, ma} * {{frsm_pkg::MUL_W{1'b0}}, mb};

  // Barrett correction: remainder below three times the prime
  assign p1      = {2'b00, frsm_pkg::PRIME};
  assign p2      = {p1[30:0], 1'b0};
  assign rem     = x_r - prod_r[31:0];
  assign fix_val = (rem >= p2) ? 30'(rem - p2) :
                   (rem >= p1) ? 30'(rem - p1) : rem[29:0];

  // doubling step, then advance by one when the exponent bit is set
  assign dbl   = frsm_pkg::mod_add(sa_r, sb_r);
  assign a_upd = exp_r[INDEX_BITS] ? frsm_pkg::mod_add(dbl, sc_r) : dbl;
  assign b_upd = exp_r[INDEX_BITS] ? dbl : sc_r;

  always_comb begin
    case (state_r)
      frsm_pkg::ST_IDLE: state_nxt = start ? frsm_pkg::ST_PREP : frsm_pkg::ST_IDLE;
      frsm_pkg::ST_PREP: state_nxt = frsm_pkg::ST_MUL;
      frsm_pkg::ST_MUL:  state_nxt = frsm_pkg::ST_BAR1;
      frsm_pkg::ST_BAR1: state_nxt = frsm_pkg::ST_BAR2;
      frsm_pkg::ST_BAR2: state_nxt = frsm_pkg::ST_FIX;
      frsm_pkg::ST_FIX: begin
        state_nxt = (op_r == frsm_pkg::OP_BT) ? frsm_pkg::ST_UPD : frsm_pkg::ST_MUL;
      end
      frsm_pkg::ST_UPD: begin
        state_nxt = ((cnt_r == '0) && pass_r) ? frsm_pkg::ST_DONE : frsm_pkg::ST_PREP;
      end
      frsm_pkg::ST_DONE: state_nxt = frsm_pkg::ST_IDLE;
      default:           state_nxt = frsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt            = op_r;
    cnt_nxt           = cnt_r;
    pass_nxt          = pass_r;
    exp_nxt           = exp_r;
    mplus_nxt         = mplus_r;
    a_nxt             = a_r;
    b_nxt             = b_r;
    t_nxt             = t_r;
    sa_nxt            = sa_r;
    sb_nxt            = sb_r;
    sc_nxt            = sc_r;
    lo_nxt            = lo_r;
    x_nxt             = x_r;
    out_valid_nxt     = 1'b0;
    out_range_sum_nxt = out_range_sum_r;
    case (state_r)
      frsm_pkg::ST_IDLE: begin
        if (start) begin
          exp_nxt   = {1'b0, in_first_index};
          mplus_nxt = {1'b0, in_last_index} + EXP_W'(1);
          a_nxt     = 30'd1;
          b_nxt     = '0;
          cnt_nxt   = CNT_W'(INDEX_BITS);
          pass_nxt  = 1'b0;
        end
      end
      frsm_pkg::ST_PREP: begin
        t_nxt  = frsm_pkg::mod_sub(frsm_pkg::mod_add(a_r, a_r), b_r);
        op_nxt = frsm_pkg::OP_AA;
      end
      frsm_pkg::ST_BAR1: begin
        x_nxt = prod_r[31:0];
      end
      frsm_pkg::ST_FIX: begin
        case (op_r)
          frsm_pkg::OP_AA: begin
            sa_nxt = fix_val;
            op_nxt = frsm_pkg::OP_BB;
          end
          frsm_pkg::OP_BB: begin
            sb_nxt = fix_val;
            op_nxt = frsm_pkg::OP_BT;
          end
          default: begin
            sc_nxt = fix_val;
          end
        endcase
      end
      frsm_pkg::ST_UPD: begin
        a_nxt   = a_upd;
        b_nxt   = b_upd;
        exp_nxt = {exp_r[EXP_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if ((cnt_r == '0) && !pass_r) begin
          lo_nxt   = a_upd;
          pass_nxt = 1'b1;
          exp_nxt  = mplus_r;
          a_nxt    = 30'd1;
          b_nxt    = '0;
          cnt_nxt  = CNT_W'(INDEX_BITS);
        end
      end
      frsm_pkg::ST_DONE: begin
        out_range_sum_nxt = frsm_pkg::mod_sub(a_r, lo_r);
        out_valid_nxt     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frsm_pkg::ST_IDLE;
      op_r        <= frsm_pkg::OP_AA;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r           <= exp_nxt;
    mplus_r         <= mplus_nxt;
    a_r             <= a_nxt;
    b_r             <= b_nxt;
    t_r             <= t_nxt;
    sa_r            <= sa_nxt;
    sb_r            <= sb_nxt;
    sc_r            <= sc_nxt;
    lo_r            <= lo_nxt;
    x_r             <= x_nxt;
    prod_r          <= mult;
    out_range_sum_r <= out_range_sum_nxt;
  end

endmodule

`default_nettype wire

### design/frsm_checker.sv
// Port-level checker for the Fibonacci range-sum block and its bind to the top level.
`default_nettype none

module frsm_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic [frsm_pkg::ELEM_W-1:0] out_range_sum
);

  a_sum_below_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_sum < frsm_pkg::PRIME))
    else $error("range sum not reduced below the prime");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result strobe");

endmodule

bind fibonacci_range_sum_mod frsm_checker u_frsm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_range_sum (out_range_sum)
);

`default_nettype wire
